// ===== rtl/hsvr_pkg.sv =====
// shared types, constants and helpers for the hsv rainbow pwm stepper
// no dependencies; imported by hsvr_alu, hsv_rainbow_pwm_stepper and hsvr_checker
`default_nettype none

package hsvr_pkg;

    localparam int unsigned NUM_W = 28;

    localparam logic [NUM_W-1:0] DIVISOR = 28'd600000;
    localparam logic [12:0]      K_FULL  = 13'd6000;

    localparam logic ALU_MUL = 1'b0;
    localparam logic ALU_DIV = 1'b1;

    localparam logic [2:0] SEC_RED     = 3'd0;
    localparam logic [2:0] SEC_YELLOW  = 3'd1;
    localparam logic [2:0] SEC_GREEN   = 3'd2;
    localparam logic [2:0] SEC_CYAN    = 3'd3;
    localparam logic [2:0] SEC_BLUE    = 3'd4;
    localparam logic [2:0] SEC_MAGENTA = 3'd5;

    typedef struct packed {
        logic             op;
        logic [NUM_W-1:0] a;
        logic [15:0]      b;
        logic [2:0]       shift;
    } alu_req_t;

    typedef struct packed {
        logic [NUM_W-1:0] res;
        logic             qbit;
    } alu_rsp_t;

    typedef struct packed {
        logic [2:0] sector;
        logic [5:0] frac;
    } hue_pos_t;

    function automatic hue_pos_t hue_split(input logic [8:0] h);
        hue_pos_t   p;
        logic [8:0] r;
        priority if (h >= 9'd300)
        begin
            p.sector = SEC_MAGENTA;
            r = h - 9'd300;
        end
        else if (h >= 9'd240)
        begin
            p.sector = SEC_BLUE;
            r = h - 9'd240;
        end
        else if (h >= 9'd180)
        begin
            p.sector = SEC_CYAN;
            r = h - 9'd180;
        end
        else if (h >= 9'd120)
        begin
            p.sector = SEC_GREEN;
            r = h - 9'd120;
        end
        else if (h >= 9'd60)
        begin
            p.sector = SEC_YELLOW;
            r = h - 9'd60;
        end
        else
        begin
            p.sector = SEC_RED;
            r = h;
        end
        p.frac = r[5:0];
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hsv_rainbow_pwm_stepper.sv =====
// HSV rainbow stepper: each request with tick set converts the stored hue to 8-bit red,
// green and blue using the configured saturation and brightness, scales each colour to a
// PWM compare value floor(colour*pwm_top/256) and then advances the hue by hue_step
// modulo 360. A request with tick clear is taken and ignored. All arithmetic runs on one
// shared multiply / compare-subtract unit: three set-up products, then per channel one
// product, eight restoring division steps by 600000 and one compare product. tick_stall is
// high outside idle, so a new request is taken only once the last one is loaded; the output
// register lets the next request in while a result still waits.
// depends on hsvr_pkg and hsvr_alu
`default_nettype none

module hsv_rainbow_pwm_stepper #(
    parameter int unsigned COMPARE_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    input  wire logic        tick_valid,
    output      logic        tick_stall,
    input  wire logic        tick,

    output      logic        result_valid,
    input  wire logic        result_stall,
    output      logic [8:0]  hue_used,
    output      logic [7:0]  red_level,
    output      logic [7:0]  green_level,
    output      logic [7:0]  blue_level,
    output      logic [15:0] red_compare,
    output      logic [15:0] green_compare,
    output      logic [15:0] blue_compare
);
    import hsvr_pkg::*;

    localparam int unsigned SAT_W = (COMPARE_WIDTH < 16) ? COMPARE_WIDTH : 16;
    localparam logic [15:0] CMP_LIMIT = 16'((33'd1 << SAT_W) - 33'd1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_CMP  = 3'd4;
    localparam logic [2:0] ST_LOAD = 3'd5;

    localparam logic [1:0] CFG_HUE_STEP   = 2'd0;
    localparam logic [1:0] CFG_SATURATION = 2'd1;
    localparam logic [1:0] CFG_BRIGHTNESS = 2'd2;
    localparam logic [1:0] CFG_PWM_TOP    = 2'd3;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [1:0]  ch_reg, ch_next;

    logic [8:0]  hue_step_reg;
    logic [6:0]  sat_reg;
    logic [6:0]  bri_reg;
    logic [15:0] pwm_top_reg;
    logic [8:0]  hue_angle_reg, hue_angle_next;
    logic        out_valid_reg, out_valid_next;

    logic [8:0]       hue_reg;
    logic [2:0]       sector_reg;
    logic [5:0]       frac_reg;
    logic [12:0]      adj_k_reg;
    logic [12:0]      mn_k_reg;
    logic [14:0]      v255_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [7:0]       quo_reg;
    logic [7:0]       level_reg [3];
    logic [15:0]      cmp_reg [3];

    logic [8:0]  hue_used_reg;
    logic [7:0]  red_level_reg, green_level_reg, blue_level_reg;
    logic [15:0] red_compare_reg, green_compare_reg, blue_compare_reg;

    logic [6:0]  sat_c, bri_c;
    logic [12:0] k_up, k_down, k_r, k_g, k_b, k_sel;
    logic [9:0]  hue_sum;
    logic [15:0] cmp_raw, cmp_sat;
    logic        take_tick, do_load;
    hue_pos_t    hue_pos;
    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;

    hsvr_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign cfg_ready  = 1'b1;
    assign tick_stall = (state_reg != ST_IDLE);
    assign take_tick  = tick_valid && !tick_stall && tick;
    assign do_load    = (state_reg == ST_LOAD) && (!out_valid_reg || !result_stall);

    assign sat_c   = (sat_reg > 7'd100) ? 7'd100 : sat_reg;
    assign bri_c   = (bri_reg > 7'd100) ? 7'd100 : bri_reg;
    assign hue_pos = hue_split(hue_angle_reg);
    assign hue_sum = {1'b0, hue_angle_reg} + {1'b0, hue_step_reg};
    assign cmp_raw = alu_rsp.res[23:8];
    assign cmp_sat = (cmp_raw > CMP_LIMIT) ? CMP_LIMIT : cmp_raw;

    // per-channel numerator factor from the hue sector
    always_comb
    begin
        k_up   = mn_k_reg + adj_k_reg;
        k_down = K_FULL - adj_k_reg;
        unique case (sector_reg)
            SEC_RED:     begin k_r = K_FULL;   k_g = k_up;     k_b = mn_k_reg; end
            SEC_YELLOW:  begin k_r = k_down;   k_g = K_FULL;   k_b = mn_k_reg; end
            SEC_GREEN:   begin k_r = mn_k_reg; k_g = K_FULL;   k_b = k_up;     end
            SEC_CYAN:    begin k_r = mn_k_reg; k_g = k_down;   k_b = K_FULL;   end
            SEC_BLUE:    begin k_r = k_up;     k_g = mn_k_reg; k_b = K_FULL;   end
            default:     begin k_r = K_FULL;   k_g = mn_k_reg; k_b = k_down;   end
        endcase
        unique case (ch_reg)
            CH_RED:   k_sel = k_r;
            CH_GREEN: k_sel = k_g;
            default:  k_sel = k_b;
        endcase
    end

    always_comb
    begin
        alu_req.op    = ALU_MUL;
        alu_req.a     = '0;
        alu_req.b     = '0;
        alu_req.shift = cnt_reg;
        unique case (state_reg)
            ST_PREP:
            begin
                if (cnt_reg == 3'd0)
                begin
                    alu_req.a = NUM_W'(sat_c);
                    alu_req.b = 16'(frac_reg);
                end
                else if (cnt_reg == 3'd1)
                begin
                    alu_req.a = NUM_W'(7'd100 - sat_c);
                    alu_req.b = 16'd60;
                end
                else
                begin
                    alu_req.a = NUM_W'(bri_c);
                    alu_req.b = 16'd255;
                end
            end
            ST_MUL:
            begin
                alu_req.a = NUM_W'(v255_reg);
                alu_req.b = 16'(k_sel);
            end
            ST_DIV:
            begin
                alu_req.op = ALU_DIV;
                alu_req.a  = rem_reg;
            end
            ST_CMP:
            begin
                alu_req.a = NUM_W'(quo_reg);
                alu_req.b = pwm_top_reg;
            end
            default:
            begin
                alu_req.op = ALU_MUL;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ch_next        = ch_reg;
        hue_angle_next = hue_angle_reg;
        out_valid_next = out_valid_reg && result_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_tick)
                begin
                    state_next = ST_PREP;
                    cnt_next   = 3'd0;
                    priority if (hue_sum >= 10'd720)
                        hue_angle_next = 9'(hue_sum - 10'd720);
                    else if (hue_sum >= 10'd360)
                        hue_angle_next = 9'(hue_sum - 10'd360);
                    else
                        hue_angle_next = hue_sum[8:0];
                end
            end
            ST_PREP:
            begin
                if (cnt_reg == 3'd2)
                begin
                    state_next = ST_MUL;
                    ch_next    = CH_RED;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
                cnt_next   = 3'd7;
            end
            ST_DIV:
            begin
                if (cnt_reg == 3'd0)
                    state_next = ST_CMP;
                else
                    cnt_next = cnt_reg - 3'd1;
            end
            ST_CMP:
            begin
                if (ch_reg == CH_BLUE)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_MUL;
                    ch_next    = ch_reg + 2'd1;
                end
            end
            ST_LOAD:
            begin
                if (do_load)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ch_reg        <= CH_RED;
            hue_angle_reg <= '0;
            out_valid_reg <= 1'b0;
            hue_step_reg  <= 9'd4;
            sat_reg       <= 7'd100;
            bri_reg       <= 7'd100;
            pwm_top_reg   <= 16'd999;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ch_reg        <= ch_next;
            hue_angle_reg <= hue_angle_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_HUE_STEP:   hue_step_reg <= cfg_data[8:0];
                    CFG_SATURATION: sat_reg      <= cfg_data[6:0];
                    CFG_BRIGHTNESS: bri_reg      <= cfg_data[6:0];
                    CFG_PWM_TOP:    pwm_top_reg  <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_tick)
        begin
            hue_reg    <= hue_angle_reg;
            sector_reg <= hue_pos.sector;
            frac_reg   <= hue_pos.frac;
        end
        if (state_reg == ST_PREP)
        begin
            if (cnt_reg == 3'd0)
                adj_k_reg <= alu_rsp.res[12:0];
            else if (cnt_reg == 3'd1)
                mn_k_reg <= alu_rsp.res[12:0];
            else
                v255_reg <= alu_rsp.res[14:0];
        end
        if (state_reg == ST_MUL)
        begin
            rem_reg <= alu_rsp.res;
            quo_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg          <= alu_rsp.res;
            quo_reg[cnt_reg] <= alu_rsp.qbit;
        end
        if (state_reg == ST_CMP)
        begin
            level_reg[ch_reg] <= quo_reg;
            cmp_reg[ch_reg]   <= cmp_sat;
        end
        if (do_load)
        begin
            hue_used_reg      <= hue_reg;
            red_level_reg     <= level_reg[CH_RED];
            green_level_reg   <= level_reg[CH_GREEN];
            blue_level_reg    <= level_reg[CH_BLUE];
            red_compare_reg   <= cmp_reg[CH_RED];
            green_compare_reg <= cmp_reg[CH_GREEN];
            blue_compare_reg  <= cmp_reg[CH_BLUE];
        end
    end

    assign result_valid  = out_valid_reg;
    assign hue_used      = hue_used_reg;
    assign red_level     = red_level_reg;
    assign green_level   = green_level_reg;
    assign blue_level    = blue_level_reg;
    assign red_compare   = red_compare_reg;
    assign green_compare = green_compare_reg;
    assign blue_compare  = blue_compare_reg;

    a_hue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        hue_angle_reg < 9'd360)
        else $error("hue angle left 0..359");

    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && !tick_stall && tick) |=> (state_reg == ST_PREP))
        else $error("accepted tick did not start conversion");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |->
            ({1'b0, rem_reg} < ({1'b0, DIVISOR} << ({1'b0, cnt_reg} + 4'd1))))
        else $error("division remainder out of range");

endmodule

`default_nettype wire

// ===== rtl/hsvr_alu.sv =====
// shared arithmetic unit: 16x16 multiply or one restoring division step
// depends on hsvr_pkg
`default_nettype none

module hsvr_alu (
    input  wire hsvr_pkg::alu_req_t req,
    output      hsvr_pkg::alu_rsp_t rsp
);
    import hsvr_pkg::*;

    logic [31:0]      prod;
    logic [NUM_W-1:0] dsh;

    always_comb
    begin
        prod = req.a[15:0] * req.b;
        dsh  = DIVISOR << req.shift;
        unique case (req.op)
            ALU_MUL:
            begin
                rsp.res  = prod[NUM_W-1:0];
                rsp.qbit = 1'b0;
            end
            ALU_DIV:
            begin
                if (req.a >= dsh)
                begin
                    rsp.res  = req.a - dsh;
                    rsp.qbit = 1'b1;
                end
                else
                begin
                    rsp.res  = req.a;
                    rsp.qbit = 1'b0;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sim/hsvr_checker.sv =====
// register indexes and colour sample type for the stepper testbench, plus the checker
// that predicts each hue-to-colour conversion and compares it with the block's results
// depends on hsvr_pkg for the sector codes
package hsvr_tb_pkg;

    typedef enum logic [1:0] {
        REG_HUE_STEP   = 2'd0,
        REG_SATURATION = 2'd1,
        REG_BRIGHTNESS = 2'd2,
        REG_PWM_TOP    = 2'd3
    } cfg_reg_e;

    typedef struct packed {
        logic [8:0]  hue;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] red_cmp;
        logic [15:0] green_cmp;
        logic [15:0] blue_cmp;
    } colour_sample_t;

endpackage

module hsvr_checker #(
    parameter int unsigned COMPARE_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        tick_valid,
    input  logic        tick_stall,
    input  logic        tick,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [8:0]  hue_used,
    input  logic [7:0]  red_level,
    input  logic [7:0]  green_level,
    input  logic [7:0]  blue_level,
    input  logic [15:0] red_compare,
    input  logic [15:0] green_compare,
    input  logic [15:0] blue_compare,
    output int          mismatches,
    output int          colours_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import hsvr_pkg::*;
    import hsvr_tb_pkg::*;

    localparam longint unsigned COLOUR_DENOM = 600000;

    logic [8:0]  hue_q;
    logic [8:0]  hue_step_q;
    logic [6:0]  sat_q;
    logic [6:0]  bright_q;
    logic [15:0] top_q;

    colour_sample_t expected_colours[$];
    colour_sample_t want;

    function automatic logic [15:0] pwm_compare(input logic [7:0] level);
        longint unsigned scaled;
        longint unsigned ceiling;
        scaled  = level;
        scaled  = (scaled * top_q) >> 8;
        ceiling = (64'd1 << COMPARE_WIDTH) - 1;
        if (scaled > ceiling)
        begin
            scaled = ceiling;
        end
        return scaled[15:0];
    endfunction

    function automatic colour_sample_t colour_for_hue(input logic [8:0] h);
        longint unsigned s_pct;
        longint unsigned v_pct;
        longint unsigned frac;
        longint unsigned peak;
        longint unsigned floor_v;
        longint unsigned ramp;
        longint unsigned r;
        longint unsigned g;
        longint unsigned b;
        logic [2:0]      sector;
        colour_sample_t  c;
        s_pct   = (sat_q > 7'd100) ? 100 : sat_q;
        v_pct   = (bright_q > 7'd100) ? 100 : bright_q;
        frac    = h % 60;
        sector  = 3'(h / 60);
        peak    = 255 * v_pct * 6000;
        floor_v = 255 * v_pct * (100 - s_pct) * 60;
        ramp    = 255 * v_pct * s_pct * frac;
        case (sector)
            SEC_RED:
            begin
                r = peak;            g = floor_v + ramp;  b = floor_v;
            end
            SEC_YELLOW:
            begin
                r = peak - ramp;     g = peak;            b = floor_v;
            end
            SEC_GREEN:
            begin
                r = floor_v;         g = peak;            b = floor_v + ramp;
            end
            SEC_CYAN:
            begin
                r = floor_v;         g = peak - ramp;     b = peak;
            end
            SEC_BLUE:
            begin
                r = floor_v + ramp;  g = floor_v;         b = peak;
            end
            default:
            begin
                r = peak;            g = floor_v;         b = peak - ramp;
            end
        endcase
        c.hue       = h;
        c.red       = 8'(r / COLOUR_DENOM);
        c.green     = 8'(g / COLOUR_DENOM);
        c.blue      = 8'(b / COLOUR_DENOM);
        c.red_cmp   = pwm_compare(c.red);
        c.green_cmp = pwm_compare(c.green);
        c.blue_cmp  = pwm_compare(c.blue);
        return c;
    endfunction

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_q       = 9'd0;
            hue_step_q  = 9'd4;
            sat_q       = 7'd100;
            bright_q    = 7'd100;
            top_q       = 16'd999;
            mismatches  = 0;
            expected_colours.delete();
            colours_due <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_HUE_STEP:   hue_step_q = cfg_data[8:0];
                    REG_SATURATION: sat_q      = cfg_data[6:0];
                    REG_BRIGHTNESS: bright_q   = cfg_data[6:0];
                    default:        top_q      = cfg_data;
                endcase
            end
            if (tick_valid && !tick_stall && tick)
            begin
                expected_colours.push_back(colour_for_hue(hue_q));
                hue_q = 9'((10'(hue_q) + 10'(hue_step_q)) % 10'd360);
            end
            if (result_valid && !result_stall)
            begin
                if (expected_colours.size() == 0)
                begin
                    $error("unexpected result: hue_used %0d", hue_used);
                    mismatches++;
                end
                else
                begin
                    want = expected_colours.pop_front();
                    check_field("hue_used", want.hue, hue_used);
                    check_field("red_level", want.red, red_level);
                    check_field("green_level", want.green, green_level);
                    check_field("blue_level", want.blue, blue_level);
                    check_field("red_compare", want.red_cmp, red_compare);
                    check_field("green_compare", want.green_cmp, green_compare);
                    check_field("blue_compare", want.blue_cmp, blue_compare);
                end
            end
            colours_due <= expected_colours.size();
        end
    end

endmodule

// ===== sim/tb_hsv_rainbow_pwm_stepper.sv =====
// top of the stepper testbench: clock, reset, register writes, tick requests and
// result back-pressure, with the verdict taken from hsvr_checker
// depends on hsvr_tb_pkg, hsvr_checker and the stepper rtl
module tb_hsv_rainbow_pwm_stepper;
    timeunit 1ns;
    timeprecision 1ps;

    import hsvr_tb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        tick_valid;
    logic        tick_stall;
    logic        tick;
    logic        result_valid;
    logic        result_stall;
    logic [8:0]  hue_used;
    logic [7:0]  red_level;
    logic [7:0]  green_level;
    logic [7:0]  blue_level;
    logic [15:0] red_compare;
    logic [15:0] green_compare;
    logic [15:0] blue_compare;
    int          mismatches;
    int          colours_due;
    bit          calm;

    hsv_rainbow_pwm_stepper #(
        .COMPARE_WIDTH(16)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .tick_valid    (tick_valid),
        .tick_stall    (tick_stall),
        .tick          (tick),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .hue_used      (hue_used),
        .red_level     (red_level),
        .green_level   (green_level),
        .blue_level    (blue_level),
        .red_compare   (red_compare),
        .green_compare (green_compare),
        .blue_compare  (blue_compare)
    );

    hsvr_checker #(
        .COMPARE_WIDTH(16)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .tick_valid    (tick_valid),
        .tick_stall    (tick_stall),
        .tick          (tick),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .hue_used      (hue_used),
        .red_level     (red_level),
        .green_level   (green_level),
        .blue_level    (blue_level),
        .red_compare   (red_compare),
        .green_compare (green_compare),
        .blue_compare  (blue_compare),
        .mismatches    (mismatches),
        .colours_due   (colours_due)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        result_stall <= !calm && ($urandom_range(0, 99) < 25);
    end

    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd359;
            3:       return 16'd360;
            4:       return 16'($urandom);
            default: return 16'($urandom_range(0, 359));
        endcase
    endfunction

    function automatic logic [15:0] pick_percent();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd100;
            2:       return 16'($urandom_range(101, 127));
            3:       return 16'($urandom);
            default: return 16'($urandom_range(0, 100));
        endcase
    endfunction

    function automatic logic [15:0] pick_top();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3:       return 16'($urandom_range(1, 255));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic write_reg(input cfg_reg_e idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic configure(input logic [15:0] step, input logic [15:0] sat,
                             input logic [15:0] bright, input logic [15:0] top);
        write_reg(REG_HUE_STEP, step);
        write_reg(REG_SATURATION, sat);
        write_reg(REG_BRIGHTNESS, bright);
        write_reg(REG_PWM_TOP, top);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_tick(input logic t);
        if (!calm && $urandom_range(0, 99) < 25)
        begin
            tick_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick       <= t;
        @(posedge clk);
        while (tick_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_ticks(input int count, input bit noisy);
        int sent;
        sent = 0;
        send_tick(1'b0);
        while (sent < count)
        begin
            if (noisy && $urandom_range(0, 99) < 15)
            begin
                send_tick(1'b0);
            end
            else
            begin
                send_tick(1'b1);
                sent++;
            end
        end
        tick_valid <= 1'b0;
    endtask

    // also covers a tick-clear request still in flight
    task automatic drain();
        int waited;
        waited = 0;
        @(posedge clk);
        while (colours_due != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_HUE_STEP;
        cfg_data     = 16'd0;
        tick_valid   = 1'b0;
        tick         = 1'b0;
        calm         = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_ticks(3, 1'b0);
        drain();
        configure(16'd60, 16'd100, 16'd100, 16'hFFFF);
        run_ticks(6, 1'b0);
        drain();
        configure(16'd59, 16'd127, 16'd127, 16'd0);
        run_ticks(7, 1'b0);
        drain();
        configure(16'd511, 16'd0, 16'd0, 16'd1);
        run_ticks(3, 1'b0);
        drain();
        configure(16'hFFFF, 16'd1, 16'd1, 16'hFFFF);
        run_ticks(3, 1'b0);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            configure(pick_step(), pick_percent(), pick_percent(), pick_top());
            calm = (phase == 2);
            run_ticks(88, 1'b1);
            drain();
            calm = 1'b0;
        end

        if (mismatches == 0 && colours_due == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
